/* sv/rpg_pkg.sv */
`timescale 1ns / 1ps
package rpg_pkg;

    // Field and datapath widths
    localparam int CW     = 11;
    localparam int TICK_W = 31;
    localparam int SSUM_W = 23;
    localparam int D8_W   = 20;
    localparam int DEN_W  = 25;
    localparam int NUM_W  = 39;
    localparam int M_W    = 23;
    localparam int GREY_W = 8;

    // Register indexes of the configuration port
    typedef enum logic {
        REG_CENTER_X = 1'b0,
        REG_CENTER_Y = 1'b1
    } rpg_reg_t;

    localparam logic [CW-1:0] CENTER_X_RST = 11'd960;
    localparam logic [CW-1:0] CENTER_Y_RST = 11'd540;

    // pi in Q56
    localparam logic [63:0] PI_Q56 = 64'h0324_3F6A_8885_A309;

    // floor(2^sh / dv), evaluated at elaboration for the phase constants
    function automatic logic [63:0] pow2_div(input int sh, input logic [63:0] dv);
        logic [63:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = sh; i >= 0; i--)
        begin
            r = (r << 1) | 64'(i == sh);
            q = q << 1;
            if (r >= dv)
            begin
                r = r - dv;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // Turn fraction per 12.8 distance step and per tick, modulo one turn
    localparam logic [63:0] K_D = pow2_div(110, 64'd5 * PI_Q56);
    localparam logic [63:0] K_T = pow2_div(119, 64'd7 * PI_Q56);

    localparam logic [29:0] PI_Q28  = 30'(PI_Q56 >> 28);
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // Work item handed from front to back
    typedef struct packed {
        logic [SSUM_W-1:0] ssum;
        logic [TICK_W-1:0] tick;
    } rpg_item_t;

    typedef struct packed {
        logic      valid;
        rpg_item_t item;
    } rpg_push_t;

endpackage

/* sv/ripple_pixel_generator.sv */
`timescale 1ns / 1ps
// Radial ripple pixel generator.
// Input channel (in_valid / in_stall): one transaction carries pixel_x,
// pixel_y and tick and asks for one pixel. Output channel (out_valid /
// out_stall): one transaction per input, grey (used for R, G and B, 1..239)
// and alpha (always 255), in input order.
// Configuration: cfg_write with cfg_index selects center_x (0) or center_y (1)
// and loads cfg_data; write only while no pixel is in flight.
// Throughput: one pixel per clock while the receiver does not stall, set
// by the fully pipelined back end (bit-serial square root and divide
// stages, one stage per cycle). From input acceptance to out_valid a pixel
// passes two front stages, the four-entry queue and 66 back stages.
// When the receiver stalls, the back end freezes with its result held in the
// output register; the queue and the front keep taking input until the
// queue is full, then in_stall rises.
// Reset clears all valid state and loads the centre to 960, 540.
module ripple_pixel_generator
    import rpg_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [CW-1:0]     cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CW-1:0]     pixel_x,
    input  logic [CW-1:0]     pixel_y,
    input  logic [TICK_W-1:0] tick,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [GREY_W-1:0] grey,
    output logic [GREY_W-1:0] alpha
);

    logic [CW-1:0] center_x_reg, center_y_reg;
    rpg_push_t     push, head;
    logic          push_ready, pop;

    // Load the centre registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= CENTER_X_RST;
            center_y_reg <= CENTER_Y_RST;
        end
        else if (cfg_write)
        begin
            case (rpg_reg_t'(cfg_index))
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    rpg_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .tick       (tick),
        .center_x   (center_x_reg),
        .center_y   (center_y_reg),
        .push       (push),
        .push_ready (push_ready)
    );

    rpg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop        (pop),
        .head       (head)
    );

    rpg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .grey      (grey)
    );

    assign alpha = 8'd255;

endmodule

/* sv/rpg_cdiv.sv */
`timescale 1ns / 1ps
module rpg_cdiv
    import rpg_pkg::*;
#(
    parameter int W  = 32,
    parameter int C  = 10,
    parameter int SW = 1
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [W-1:0]  din,
    input  logic [SW-1:0] side_in,
    output logic [W-1:0]  q,
    output logic [SW-1:0] side_out
);

    localparam logic [W:0]   SPAN  = (W+1)'(1) << W;
    localparam logic [W-1:0] RECIP = W'(SPAN / C);
    localparam logic [W-1:0] DIV   = W'(C);

    logic [2*W-1:0] prod;
    logic [W-1:0]   v_reg;
    logic [W-1:0]   qe_reg;
    logic [SW-1:0]  s1_reg;
    logic [W-1:0]   rem;
    logic [W-1:0]   q_reg;
    logic [SW-1:0]  s2_reg;

    // Estimate the quotient by reciprocal multiply; it is low by at most one
    assign prod = din * RECIP;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg  <= din;
            qe_reg <= prod[2*W-1:W];
            s1_reg <= side_in;
        end
    end

    // Correct the estimate with one compare
    assign rem = v_reg - qe_reg * DIV;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg  <= qe_reg + W'(rem >= DIV);
            s2_reg <= s1_reg;
        end
    end

    assign q        = q_reg;
    assign side_out = s2_reg;

endmodule

/* sv/rpg_front.sv */
`timescale 1ns / 1ps
module rpg_front
    import rpg_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CW-1:0]     pixel_x,
    input  logic [CW-1:0]     pixel_y,
    input  logic [TICK_W-1:0] tick,
    input  logic [CW-1:0]     center_x,
    input  logic [CW-1:0]     center_y,
    output rpg_push_t         push,
    input  logic              push_ready
);

    localparam logic [13:0]   LIM_X = 14'(MAX_WIDTH);
    localparam logic [13:0]   LIM_Y = 14'(MAX_HEIGHT);
    localparam logic [CW-1:0] TOP_X = CW'(MAX_WIDTH - 1);
    localparam logic [CW-1:0] TOP_Y = CW'(MAX_HEIGHT - 1);

    logic              f_en;
    logic [CW-1:0]     px, py, cx, cy;
    logic              f1_vld_reg;
    logic [CW-1:0]     dx_reg, dy_reg;
    logic [TICK_W-1:0] tick1_reg;
    logic [2*CW-1:0]   sqx, sqy;
    logic              f2_vld_reg;
    rpg_item_t         item_reg;

    // Advance the front whenever its last stage is free or drains
    assign f_en     = !f2_vld_reg || push_ready;
    assign in_stall = !f_en;

    // Saturate coordinates to the frame
    assign px = ({3'b0, pixel_x}  >= LIM_X) ? TOP_X : pixel_x;
    assign py = ({3'b0, pixel_y}  >= LIM_Y) ? TOP_Y : pixel_y;
    assign cx = ({3'b0, center_x} >= LIM_X) ? TOP_X : center_x;
    assign cy = ({3'b0, center_y} >= LIM_Y) ? TOP_Y : center_y;

    // Take absolute offsets from the centre
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
        end
        else if (f_en)
        begin
            f1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_en)
        begin
            dx_reg    <= (px > cx) ? px - cx : cx - px;
            dy_reg    <= (py > cy) ? py - cy : cy - py;
            tick1_reg <= tick;
        end
    end

    // Form the squared distance
    assign sqx = dx_reg * dx_reg;
    assign sqy = dy_reg * dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f2_vld_reg <= 1'b0;
        end
        else if (f_en)
        begin
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_en)
        begin
            item_reg.ssum <= SSUM_W'(sqx) + SSUM_W'(sqy);
            item_reg.tick <= tick1_reg;
        end
    end

    assign push.valid = f2_vld_reg;
    assign push.item  = item_reg;

endmodule

/* sv/rpg_queue.sv */
`timescale 1ns / 1ps
module rpg_queue
    import rpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  rpg_push_t push,
    output logic      push_ready,
    input  logic      pop,
    output rpg_push_t head
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    rpg_item_t     mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != (PW+1)'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = mem[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && head.valid;

    // Store an incoming transaction
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.item;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end

endmodule

/* sv/rpg_back.sv */
`timescale 1ns / 1ps
module rpg_back
    import rpg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rpg_push_t         head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [GREY_W-1:0] grey
);

    localparam int SQ_N   = D8_W;
    localparam int SQ_RW  = 2 * D8_W;
    localparam int STEP_N = 4;
    localparam int STEP_DIV [STEP_N] = '{90, 56, 30, 12};
    localparam int SIDE_W = 1 + DEN_W + 32;
    localparam int LAT    = SQ_N + 2 + 3 + 3 + 3 * STEP_N + 1 + 1 + M_W + 1;
    localparam logic [DEN_W-1:0] DEN_ONE = DEN_W'(65536);
    localparam logic [NUM_W-1:0] SCALE   = NUM_W'(476);
    localparam logic [23:0]      BASE    = 24'(120 * 65536);

    logic               en;
    logic [LAT-1:0]     vld_reg;

    logic [SQ_RW-1:0]   sq_rem_reg  [SQ_N];
    logic [SQ_N-1:0]    sq_root_reg [SQ_N];
    logic [TICK_W-1:0]  sq_tick_reg [SQ_N];

    logic [27:0]        q10;
    logic [D8_W+TICK_W-1:0] side10;
    logic [D8_W-1:0]    d8_b;
    logic [TICK_W-1:0]  tick_b;

    logic [51:0]        ad_lo_reg;
    logic [31:0]        ad_hi_reg;
    logic [62:0]        bt_lo_reg;
    logic [31:0]        bt_hi_reg;
    logic [DEN_W-1:0]   p1_den_reg, p2_den_reg, p3_den_reg;
    logic [63:0]        pa_reg, pb_reg, phase;
    logic [23:0]        u_reg;

    logic [22:0]        r_reg;
    logic               c1_neg_reg, c2_neg_reg, c3_neg_reg;
    logic [DEN_W-1:0]   c1_den_reg, c2_den_reg, c3_den_reg;
    logic [52:0]        xp;
    logic [30:0]        x_reg;
    logic [61:0]        xx;
    logic [31:0]        x2_reg;

    logic [31:0]        st_v_reg    [STEP_N];
    logic [SIDE_W-1:0]  st_side_reg [STEP_N];

    logic [30:0]        h;
    logic [30:0]        c_reg;
    logic               cc_neg_reg, n_neg_reg;
    logic [DEN_W-1:0]   cc_den_reg, n_den_reg;
    logic [NUM_W-1:0]   num_reg;

    logic [NUM_W-1:0]   dv_rem_reg [M_W];
    logic [M_W-1:0]     dv_q_reg   [M_W];
    logic [DEN_W-1:0]   dv_den_reg [M_W];
    logic               dv_neg_reg [M_W];

    logic [23:0]        sum;
    logic [GREY_W-1:0]  grey_reg;

    // Advance the whole pipeline unless the output register is held
    assign en  = !vld_reg[LAT-1] || !out_stall;
    assign pop = en && head.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], head.valid};
        end
    end

    // Extract the square root one bit per stage
    for (genvar j = 0; j < SQ_N; j++)
    begin : g_sq
        localparam int B = SQ_N - 1 - j;
        logic [SQ_RW-1:0]  rem_in;
        logic [SQ_N-1:0]   root_in;
        logic [TICK_W-1:0] tick_in;
        logic [SQ_RW:0]    trial;

        if (j == 0)
        begin : g_first
            assign rem_in  = SQ_RW'({head.item.ssum, 16'b0});
            assign root_in = '0;
            assign tick_in = head.item.tick;
        end
        else
        begin : g_next
            assign rem_in  = sq_rem_reg[j-1];
            assign root_in = sq_root_reg[j-1];
            assign tick_in = sq_tick_reg[j-1];
        end

        assign trial = ((SQ_RW+1)'(root_in) << (B + 1)) + ((SQ_RW+1)'(1) << (2 * B));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if ({1'b0, rem_in} >= trial)
                begin
                    sq_rem_reg[j]  <= rem_in - trial[SQ_RW-1:0];
                    sq_root_reg[j] <= root_in | (SQ_N'(1) << B);
                end
                else
                begin
                    sq_rem_reg[j]  <= rem_in;
                    sq_root_reg[j] <= root_in;
                end
                sq_tick_reg[j] <= tick_in;
            end
        end
    end

    // Divide the scaled distance by ten for the denominator
    rpg_cdiv #(
        .W  (28),
        .C  (10),
        .SW (D8_W + TICK_W)
    ) u_div10 (
        .clk      (clk),
        .en       (en),
        .din      ({sq_root_reg[SQ_N-1], 8'b0}),
        .side_in  ({sq_root_reg[SQ_N-1], sq_tick_reg[SQ_N-1]}),
        .q        (q10),
        .side_out (side10)
    );

    assign d8_b   = side10[D8_W+TICK_W-1:TICK_W];
    assign tick_b = side10[TICK_W-1:0];

    // Form the phase partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ad_lo_reg  <= d8_b * K_D[31:0];
            ad_hi_reg  <= 32'(d8_b * K_D[63:32]);
            bt_lo_reg  <= tick_b * K_T[31:0];
            bt_hi_reg  <= 32'(tick_b * K_T[63:32]);
            p1_den_reg <= DEN_W'(q10) + DEN_ONE;
        end
    end

    // Sum the partial products, then take the turn fraction
    assign phase = pa_reg - pb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg     <= 64'(ad_lo_reg) + {ad_hi_reg, 32'b0};
            pb_reg     <= 64'(bt_lo_reg) + {bt_hi_reg, 32'b0};
            p2_den_reg <= p1_den_reg;
            u_reg      <= phase[63:40];
            p3_den_reg <= p2_den_reg;
        end
    end

    // Fold the angle into the first quadrant
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg      <= u_reg[22] ? 23'h40_0000 - {1'b0, u_reg[21:0]}
                                    : {1'b0, u_reg[21:0]};
            c1_neg_reg <= u_reg[23] ^ u_reg[22];
            c1_den_reg <= p3_den_reg;
        end
    end

    // Convert to Q30 radians and square
    assign xp = r_reg * PI_Q28;
    assign xx = x_reg * x_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg      <= xp[51:21];
            c2_neg_reg <= c1_neg_reg;
            c2_den_reg <= c1_den_reg;
            x2_reg     <= xx[61:30];
            c3_neg_reg <= c2_neg_reg;
            c3_den_reg <= c2_den_reg;
        end
    end

    // Run the Horner steps of the cosine series
    for (genvar k = 0; k < STEP_N; k++)
    begin : g_step
        logic [31:0]       s_din;
        logic [SIDE_W-1:0] s_side;
        logic [31:0]       q;
        logic [SIDE_W-1:0] qside;
        logic [30:0]       t;
        logic [62:0]       mp;

        if (k == 0)
        begin : g_first
            assign s_din  = x2_reg;
            assign s_side = {c3_neg_reg, c3_den_reg, x2_reg};
        end
        else
        begin : g_next
            assign s_din  = st_v_reg[k-1];
            assign s_side = st_side_reg[k-1];
        end

        rpg_cdiv #(
            .W  (32),
            .C  (STEP_DIV[k]),
            .SW (SIDE_W)
        ) u_cdiv (
            .clk      (clk),
            .en       (en),
            .din      (s_din),
            .side_in  (s_side),
            .q        (q),
            .side_out (qside)
        );

        assign t  = ONE_Q30 - q[30:0];
        assign mp = qside[31:0] * t;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_v_reg[k]    <= mp[61:30];
                st_side_reg[k] <= qside;
            end
        end
    end

    // Finish the cosine and clamp at zero
    assign h = st_v_reg[STEP_N-1][31:1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg      <= (h >= ONE_Q30) ? '0 : ONE_Q30 - h;
            cc_neg_reg <= st_side_reg[STEP_N-1][SIDE_W-1];
            cc_den_reg <= st_side_reg[STEP_N-1][SIDE_W-2:32];
            num_reg    <= NUM_W'(c_reg) * SCALE;
            n_neg_reg  <= cc_neg_reg;
            n_den_reg  <= cc_den_reg;
        end
    end

    // Divide by the denominator one quotient bit per stage
    for (genvar j = 0; j < M_W; j++)
    begin : g_dv
        localparam int B = M_W - 1 - j;
        logic [NUM_W-1:0] rem_in;
        logic [M_W-1:0]   q_in;
        logic [DEN_W-1:0] den_in;
        logic             neg_in;
        logic [47:0]      sub;

        if (j == 0)
        begin : g_first
            assign rem_in = num_reg;
            assign q_in   = '0;
            assign den_in = n_den_reg;
            assign neg_in = n_neg_reg;
        end
        else
        begin : g_next
            assign rem_in = dv_rem_reg[j-1];
            assign q_in   = dv_q_reg[j-1];
            assign den_in = dv_den_reg[j-1];
            assign neg_in = dv_neg_reg[j-1];
        end

        assign sub = 48'(den_in) << B;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (48'(rem_in) >= sub)
                begin
                    dv_rem_reg[j] <= rem_in - sub[NUM_W-1:0];
                    dv_q_reg[j]   <= q_in | (M_W'(1) << B);
                end
                else
                begin
                    dv_rem_reg[j] <= rem_in;
                    dv_q_reg[j]   <= q_in;
                end
                dv_den_reg[j] <= den_in;
                dv_neg_reg[j] <= neg_in;
            end
        end
    end

    // Offset around mid grey and register the result
    assign sum = dv_neg_reg[M_W-1] ? BASE - 24'(dv_q_reg[M_W-1])
                                   : BASE + 24'(dv_q_reg[M_W-1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            grey_reg <= sum[23:16];
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign grey      = grey_reg;

endmodule
